// ===== src/dutc_pkg.sv =====
package dutc_pkg;

  // register stages from input to result
  localparam int NUM_STAGES = 8;
  localparam int MONTHS = 12;

  localparam logic [16:0] SECS_PER_DAY = 17'd86400;

  // days from 1970-01-01 to 1980-01-01, and the same plus one for the day field base
  localparam logic [15:0] EPOCH_DAYS_U2F = 16'd3652;
  localparam logic [15:0] EPOCH_DAYS_F2U = 16'd3653;

  // packed date for 1980-01-01
  localparam logic [15:0] DOS_DATE_EPOCH = 16'h0021;

  // reciprocals for division by constants: q = (x * RECIP) >> SHIFT
  // 675: floor reciprocal, result low by at most one, fixed up later
  localparam logic [25:0] RECIP_675 = 26'd50903316;
  localparam int SHIFT_675 = 35;
  // 225, 365 and 15: ceiling reciprocals, exact over the ranges used
  localparam logic [12:0] RECIP_225 = 13'd4661;
  localparam int SHIFT_225 = 20;
  localparam logic [15:0] RECIP_365 = 16'd45965;
  localparam int SHIFT_365 = 24;
  localparam logic [12:0] RECIP_15 = 13'd4370;
  localparam int SHIFT_15 = 16;

  // first day of each month in a non-leap year, zero past december
  function automatic logic [8:0] month_start(input logic [3:0] idx);
    logic [8:0] v;
    unique case (idx)
      4'd0:    v = 9'd0;
      4'd1:    v = 9'd31;
      4'd2:    v = 9'd59;
      4'd3:    v = 9'd90;
      4'd4:    v = 9'd120;
      4'd5:    v = 9'd151;
      4'd6:    v = 9'd181;
      4'd7:    v = 9'd212;
      4'd8:    v = 9'd243;
      4'd9:    v = 9'd273;
      4'd10:   v = 9'd304;
      4'd11:   v = 9'd334;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== src/dutc_ctrl.sv =====
module dutc_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [dutc_pkg::NUM_STAGES-1:0] ld
);
  import dutc_pkg::*;

  logic [NUM_STAGES-1:0] vld;

  // a stage loads when it is empty or its contents move on
  always_comb begin
    ld[NUM_STAGES-1] = ~vld[NUM_STAGES-1] | out_ready;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      ld[i] = ~vld[i] | ld[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ld[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (ld[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  assign in_ready  = ld[0];
  assign out_valid = vld[NUM_STAGES-1];

endmodule

// ===== src/dutc_fat2unix.sv =====
module dutc_fat2unix (
  input  logic                            clk,
  input  logic [dutc_pkg::NUM_STAGES-1:0] ld,
  input  logic                            kind,
  input  logic [15:0]                     dos_time,
  input  logic [15:0]                     dos_date,
  output logic [32:0]                     unix_result
);
  import dutc_pkg::*;

  logic [3:0]  mon;
  logic [6:0]  yr;
  logic [8:0]  offset;
  logic        leap_adj;
  logic [15:0] days_next;
  logic [16:0] tsec_next;

  logic [15:0] days0;
  logic [16:0] tsec0;
  logic        kind0;
  logic [32:0] prod1;
  logic [16:0] tsec1;
  logic        kind1;
  logic [32:0] res [2:NUM_STAGES-1];

  always_comb begin
    mon      = dos_date[8:5];
    yr       = dos_date[15:9];
    offset   = (mon == 4'd0) ? 9'd0 : month_start(mon - 4'd1);
    // leap day not yet reached in january and february of a leap year
    leap_adj = (yr[1:0] == 2'd0) && (mon <= 4'd2);
    days_next = 16'(dos_date[4:0]) + 16'(offset) + 16'(yr[6:2]) + 16'(yr) * 16'd365
              + EPOCH_DAYS_F2U - 16'd1 - 16'(leap_adj);
    tsec_next = 17'(dos_time[4:0]) * 17'd2 + 17'(dos_time[10:5]) * 17'd60
              + 17'(dos_time[15:11]) * 17'd3600;
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      days0 <= days_next;
      tsec0 <= tsec_next;
      kind0 <= kind;
    end
    if (ld[1]) begin
      prod1 <= 33'(days0) * 33'(SECS_PER_DAY);
      tsec1 <= tsec0;
      kind1 <= kind0;
    end
    if (ld[2]) begin
      res[2] <= kind1 ? 33'd0 : prod1 + 33'(tsec1);
    end
    for (int i = 3; i < NUM_STAGES; i++) begin
      if (ld[i]) begin
        res[i] <= res[i-1];
      end
    end
  end

  assign unix_result = res[NUM_STAGES-1];

endmodule

// ===== src/dutc_unix2fat.sv =====
module dutc_unix2fat (
  input  logic                            clk,
  input  logic [dutc_pkg::NUM_STAGES-1:0] ld,
  input  logic                            kind,
  input  logic [31:0]                     unix_seconds,
  output logic [15:0]                     dos_time_out,
  output logic [15:0]                     dos_date_out,
  output logic                            clamped
);
  import dutc_pkg::*;

  // stage 0: day count estimate, seconds / 86400 as (seconds >> 7) / 675
  logic [24:0] x;
  logic [50:0] qprod;
  logic [15:0] q0_0;
  logic [24:0] x0;
  logic [6:0]  lo0;
  logic        kind0;

  // stage 1: remainder of the estimate
  logic [25:0] qm;
  logic [10:0] rx1;
  logic [15:0] q1;
  logic [6:0]  lo1;
  logic        kind1;

  // stage 2: fix-up, seconds of day, days since 1980
  logic        over;
  logic [15:0] q2_next;
  logic [10:0] r2;
  logic [16:0] sod2;
  logic [15:0] day2;
  logic        clamp2;
  logic        kind2;

  // stage 3: hour and year estimate
  logic [25:0] hprod;
  logic [31:0] yprod;
  logic [4:0]  h3;
  logic [6:0]  yr0_3;
  logic [16:0] sod3;
  logic [15:0] day3;
  logic        clamp3;
  logic        kind3;

  // stage 4: seconds within hour, day base of candidate years
  logic [16:0] hm;
  logic [7:0]  yr_p3;
  logic [7:0]  yr_p2;
  logic [6:0]  yr_m1;
  logic [15:0] base0_next;
  logic [15:0] base1_next;
  logic [11:0] mrem4;
  logic [15:0] base0_4;
  logic [15:0] base1_4;
  logic [6:0]  yr0_4;
  logic [15:0] day4;
  logic [4:0]  h4;
  logic        clamp4;
  logic        kind4;

  // stage 5: year fix-up, day of year, minutes
  logic        fix;
  logic [15:0] doy_full;
  logic [22:0] mprod;
  logic [6:0]  year5;
  logic [8:0]  doy5;
  logic [5:0]  mn5;
  logic [5:0]  mrem5;
  logic [4:0]  h5;
  logic        clamp5;
  logic        kind5;

  // stage 6: seconds, month search
  logic [11:0] mm;
  logic [5:0]  sec6;
  logic        leap;
  logic        feb29;
  logic [8:0]  nl;
  logic [3:0]  cnt;
  logic [3:0]  month_next;
  logic [15:0] tm6;
  logic [8:0]  nl6;
  logic [3:0]  month6;
  logic [6:0]  year6;
  logic        clamp6;
  logic        kind6;

  // stage 7: packed date
  logic [8:0]  dom;
  logic [15:0] date_next;

  assign x     = unix_seconds[31:7];
  assign qprod = 51'(x) * 51'(RECIP_675);

  assign qm = 26'(q0_0) * 26'd675;

  always_comb begin
    over    = rx1 >= 11'd675;
    q2_next = q1 + 16'(over);
    r2      = over ? rx1 - 11'd675 : rx1;
  end

  assign hprod = 26'(sod2[16:4]) * 26'(RECIP_225);
  assign yprod = 32'(day2) * 32'(RECIP_365);

  always_comb begin
    hm         = 17'(h3) * 17'd3600;
    yr_p3      = 8'(yr0_3) + 8'd3;
    yr_p2      = 8'(yr0_3) + 8'd2;
    yr_m1      = yr0_3 - 7'd1;
    base0_next = 16'(yr_p3[7:2]) + 16'(yr0_3) * 16'd365;
    base1_next = 16'(yr_p2[7:2]) + 16'(yr_m1) * 16'd365;
  end

  always_comb begin
    // estimate one year too far when the leap days push the base past the day
    fix      = base0_4 > day4;
    doy_full = day4 - (fix ? base1_4 : base0_4);
    mprod    = 23'(mrem4[11:2]) * 23'(RECIP_15);
  end

  always_comb begin
    mm    = 12'(mn5) * 12'd60;
    sec6  = mrem5 - mm[5:0];
    leap  = (year5[1:0] == 2'd0);
    feb29 = leap && (doy5 == 9'd59);
    nl    = (!leap || doy5 <= 9'd59) ? doy5 : doy5 - 9'd1;
    // table rises, so the last entry not above the day gives the month
    cnt   = 4'd0;
    for (int i = 0; i < MONTHS; i++) begin
      if (month_start(4'(i)) <= nl) begin
        cnt = 4'(i + 1);
      end
    end
    month_next = feb29 ? 4'd2 : cnt;
  end

  always_comb begin
    dom       = nl6 - month_start(month6 - 4'd1) + 9'd1;
    date_next = 16'(dom) + 16'({month6, 5'd0}) + 16'({year6, 9'd0});
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      q0_0  <= qprod[SHIFT_675 +: 16];
      x0    <= x;
      lo0   <= unix_seconds[6:0];
      kind0 <= kind;
    end
    if (ld[1]) begin
      rx1   <= x0[10:0] - qm[10:0];
      q1    <= q0_0;
      lo1   <= lo0;
      kind1 <= kind0;
    end
    if (ld[2]) begin
      sod2   <= {r2[9:0], lo1};
      day2   <= q2_next - EPOCH_DAYS_U2F;
      clamp2 <= q2_next < EPOCH_DAYS_U2F;
      kind2  <= kind1;
    end
    if (ld[3]) begin
      h3     <= hprod[SHIFT_225 +: 5];
      yr0_3  <= yprod[SHIFT_365 +: 7];
      sod3   <= sod2;
      day3   <= day2;
      clamp3 <= clamp2;
      kind3  <= kind2;
    end
    if (ld[4]) begin
      mrem4   <= sod3[11:0] - hm[11:0];
      base0_4 <= base0_next;
      base1_4 <= base1_next;
      yr0_4   <= yr0_3;
      day4    <= day3;
      h4      <= h3;
      clamp4  <= clamp3;
      kind4   <= kind3;
    end
    if (ld[5]) begin
      year5  <= fix ? yr0_4 - 7'd1 : yr0_4;
      doy5   <= doy_full[8:0];
      mn5    <= mprod[SHIFT_15 +: 6];
      mrem5  <= mrem4[5:0];
      h5     <= h4;
      clamp5 <= clamp4;
      kind5  <= kind4;
    end
    if (ld[6]) begin
      tm6    <= {h5, mn5, sec6[5:1]};
      nl6    <= nl;
      month6 <= month_next;
      year6  <= year5;
      clamp6 <= clamp5;
      kind6  <= kind5;
    end
    if (ld[NUM_STAGES-1]) begin
      if (!kind6) begin
        dos_time_out <= 16'd0;
        dos_date_out <= 16'd0;
        clamped      <= 1'b0;
      end else if (clamp6) begin
        dos_time_out <= 16'd0;
        dos_date_out <= DOS_DATE_EPOCH;
        clamped      <= 1'b1;
      end else begin
        dos_time_out <= tm6;
        dos_date_out <= date_next;
        clamped      <= 1'b0;
      end
    end
  end

endmodule

// ===== src/dos_unix_timestamp_convert_core.sv =====
// FAT timestamp converter. Each request carries kind: 0 turns a packed FAT
// time/date pair into seconds since 1970 (exact, 33 bits), 1 turns 32-bit Unix
// seconds into a packed FAT pair, clamping anything before 1980 to 1980-01-01
// 00:00:00 with clamped set. Fields of the other direction come back as zero.
// Both paths hold each request in eight register stages, the first of which
// captures it at acceptance; on the Unix-to-FAT path these do the division by
// 86400, then the hour and year estimates, fix-ups, month search and packing.
// One request is accepted per cycle while in_ready is high; a stalled output
// holds only the full stages behind it, and empty stages keep filling while
// the result waits.
module dos_unix_timestamp_convert_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [15:0] dos_time,
  input  logic [15:0] dos_date,
  input  logic [31:0] unix_seconds,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [32:0] unix_result,
  output logic [15:0] dos_time_out,
  output logic [15:0] dos_date_out,
  output logic        clamped
);
  import dutc_pkg::*;

  logic [NUM_STAGES-1:0] ld;

  dutc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ld        (ld)
  );

  dutc_fat2unix u_fat2unix (
    .clk         (clk),
    .ld          (ld),
    .kind        (kind),
    .dos_time    (dos_time),
    .dos_date    (dos_date),
    .unix_result (unix_result)
  );

  dutc_unix2fat u_unix2fat (
    .clk          (clk),
    .ld           (ld),
    .kind         (kind),
    .unix_seconds (unix_seconds),
    .dos_time_out (dos_time_out),
    .dos_date_out (dos_date_out),
    .clamped      (clamped)
  );

endmodule

// ===== sim/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dutc_pkg::*;

  localparam time CLK_PERIOD = 10ns;
  localparam int RESET_CYCLES = 12;
  localparam int IDLE_PCT = 33;
  localparam int STALL_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 4000;

  localparam logic KIND_FAT2UNIX = 1'b0;
  localparam logic KIND_UNIX2FAT = 1'b1;

  // first second of 1980-01-01
  localparam logic [31:0] UNIX_1980 = 32'd315532800;

  typedef struct packed {
    logic [32:0] unix_result;
    logic [15:0] dos_time;
    logic [15:0] dos_date;
    logic        clamped;
  } stamp_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        kind = KIND_FAT2UNIX;
  logic [15:0] dos_time = '0;
  logic [15:0] dos_date = '0;
  logic [31:0] unix_seconds = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [32:0] unix_result;
  logic [15:0] dos_time_out;
  logic [15:0] dos_date_out;
  logic        clamped;

  stamp_result_t pending_stamps[$];
  int unsigned   error_count = 0;
  int unsigned   results_seen = 0;
  int unsigned   fat_requests = 0;
  int unsigned   unix_requests = 0;
  int unsigned   clamp_requests = 0;
  int unsigned   quiet_cycles = 0;
  int unsigned   hold_left = 0;
  bit            src_steady = 1'b0;
  bit            sink_steady = 1'b0;
  bit            hold_req = 1'b0;

  dos_unix_timestamp_convert_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .dos_time     (dos_time),
    .dos_date     (dos_date),
    .unix_seconds (unix_seconds),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .unix_result  (unix_result),
    .dos_time_out (dos_time_out),
    .dos_date_out (dos_date_out),
    .clamped      (clamped)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // days before the start of a month, non-leap year; nothing past december
  function automatic int unsigned month_offset(input int unsigned idx);
    case (idx)
      1:       return 31;
      2:       return 59;
      3:       return 90;
      4:       return 120;
      5:       return 151;
      6:       return 181;
      7:       return 212;
      8:       return 243;
      9:       return 273;
      10:      return 304;
      11:      return 334;
      default: return 0;
    endcase
  endfunction

  function automatic stamp_result_t predict_stamp(input logic k, input logic [15:0] t,
                                                  input logic [15:0] d, input logic [31:0] u);
    stamp_result_t r;
    longint        days;
    longint        secs;
    longint        fyear;
    int unsigned   mon;
    int unsigned   secs_in;
    int unsigned   dnum;
    int unsigned   yr;
    int unsigned   nl;
    int unsigned   m;
    int            i;
    r = '0;
    if (k == KIND_FAT2UNIX) begin
      mon = d[8:5];
      fyear = longint'(d[15:9]);
      days = longint'(d[4:0]) - 1 + longint'((mon == 0) ? 0 : month_offset(mon - 1))
           + fyear / 4 + fyear * 365 + 3653;
      // leap-day correction only applies to month fields 0 to 2
      if (fyear % 4 == 0 && mon <= 2) days = days - 1;
      secs = longint'(t[4:0]) * 2 + longint'(t[10:5]) * 60 + longint'(t[15:11]) * 3600
           + days * 86400;
      r.unix_result = 33'(secs);
    end else begin
      secs_in = u;
      if (secs_in / 86400 < 3652) begin
        r.dos_date = 16'h0021;
        r.clamped = 1'b1;
      end else begin
        r.dos_time = 16'((secs_in % 60) / 2 + (((secs_in / 60) % 60) << 5)
                         + (((secs_in / 3600) % 24) << 11));
        dnum = secs_in / 86400 - 3652;
        yr = dnum / 365;
        if ((yr + 3) / 4 + 365 * yr > dnum) yr = yr - 1;
        dnum = dnum - ((yr + 3) / 4 + 365 * yr);
        if (dnum == 59 && yr % 4 == 0) begin
          nl = dnum;
          m = 2;
        end else begin
          nl = (yr % 4 != 0 || dnum <= 59) ? dnum : dnum - 1;
          m = 12;
          for (i = 11; i >= 0; i--) begin
            if (month_offset(i) > nl) m = i;
          end
        end
        r.dos_date = 16'(nl - month_offset((m - 1) & 15) + 1 + (m << 5) + (yr << 9));
      end
    end
    return r;
  endfunction

  task automatic send_request(input logic k, input logic [15:0] t, input logic [15:0] d,
                              input logic [31:0] u);
    stamp_result_t p;
    while (!src_steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    dos_time <= t;
    dos_date <= d;
    unix_seconds <= u;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    p = predict_stamp(k, t, d, u);
    pending_stamps.push_back(p);
    if (k == KIND_FAT2UNIX) fat_requests++;
    else unix_requests++;
    if (p.clamped) clamp_requests++;
  endtask

  // mostly well-formed stamps, with raw noise and boundary seconds mixed in
  task automatic random_request();
    logic [15:0] t;
    logic [15:0] d;
    logic [31:0] u;
    int unsigned pick;
    t = 16'($urandom);
    d = 16'($urandom);
    u = $urandom;
    pick = $urandom_range(99);
    if ($urandom_range(1) == 0) begin
      if (pick < 75) begin
        t = {5'($urandom_range(23)), 6'($urandom_range(59)), 5'($urandom_range(29))};
        d = {7'($urandom_range(127)), 4'($urandom_range(12, 1)), 5'($urandom_range(31, 1))};
      end
      send_request(KIND_FAT2UNIX, t, d, u);
    end else begin
      if (pick < 15) u = $urandom_range(UNIX_1980 - 1, 0);
      else if (pick < 45)
        u = $urandom_range(49709, 3652) * 86400 + (($urandom_range(1) == 0) ? 0 : 86399);
      else if (pick < 80) u = $urandom_range(32'hFFFF_FFFF, UNIX_1980);
      send_request(KIND_UNIX2FAT, t, d, u);
    end
  endtask

  task automatic compare_field(input string name, input logic [32:0] want,
                               input logic [32:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  // response side: random stalls, always ready when held steady, or a long hold-off when asked for one
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req) begin
      out_ready <= 1'b0;
      hold_left <= STALL_CYCLES;
      hold_req <= 1'b0;
    end else if (sink_steady) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    stamp_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_stamps.size() == 0) begin
        $display("%0t: result with no request outstanding: unix %0d time %h date %h clamped %b",
                 $time, unix_result, dos_time_out, dos_date_out, clamped);
        error_count++;
      end else begin
        want = pending_stamps.pop_front();
        compare_field("unix_result", want.unix_result, unix_result);
        compare_field("dos_time_out", 33'(want.dos_time), 33'(dos_time_out));
        compare_field("dos_date_out", 33'(want.dos_date), 33'(dos_date_out));
        compare_field("clamped", 33'(want.clamped), 33'(clamped));
        results_seen++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no request or result moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic test_fat_corners();
    send_request(KIND_FAT2UNIX, 16'h0000, 16'h0000, 32'hFFFF_FFFF);
    send_request(KIND_FAT2UNIX, 16'hFFFF, 16'hFFFF, 32'h0000_0000);
    // leap day of 1980 against the first of march
    send_request(KIND_FAT2UNIX, {5'd23, 6'd59, 5'd29}, {7'd0, 4'd2, 5'd29}, 32'd0);
    send_request(KIND_FAT2UNIX, 16'h0000, {7'd0, 4'd3, 5'd1}, 32'd0);
    // month fields past december
    send_request(KIND_FAT2UNIX, 16'h0841, {7'd1, 4'd13, 5'd10}, 32'd0);
    send_request(KIND_FAT2UNIX, 16'h1234, {7'd2, 4'd14, 5'd0}, 32'd0);
    send_request(KIND_FAT2UNIX, 16'h0001, {7'd3, 4'd15, 5'd5}, 32'd0);
    // subfields above their normal range, then a zero day field and 2100-02-29
    send_request(KIND_FAT2UNIX, {5'd31, 6'd63, 5'd31}, {7'd127, 4'd12, 5'd31}, 32'd0);
    send_request(KIND_FAT2UNIX, 16'h0000, {7'd4, 4'd1, 5'd0}, 32'd0);
    send_request(KIND_FAT2UNIX, 16'h0000, {7'd120, 4'd2, 5'd29}, 32'd0);
  endtask

  task automatic test_unix_corners();
    send_request(KIND_UNIX2FAT, 16'hFFFF, 16'hFFFF, 32'd0);
    send_request(KIND_UNIX2FAT, 16'h0000, 16'h0000, UNIX_1980 - 1);
    send_request(KIND_UNIX2FAT, 16'h0000, 16'h0000, UNIX_1980);
    send_request(KIND_UNIX2FAT, 16'h0000, 16'h0000, UNIX_1980 + 1);
    send_request(KIND_UNIX2FAT, 16'h0000, 16'h0000, 32'd320630400);
    send_request(KIND_UNIX2FAT, 16'h0000, 16'h0000, 32'd320716800);
    send_request(KIND_UNIX2FAT, 16'h0000, 16'h0000, 32'd347155199);
    // 2100 is taken as a leap year
    send_request(KIND_UNIX2FAT, 16'h0000, 16'h0000, 32'd4107542400);
    send_request(KIND_UNIX2FAT, 16'h0000, 16'h0000, 32'd4107628800);
    send_request(KIND_UNIX2FAT, 16'h0000, 16'h0000, 32'hFFFF_FFFF);
    send_request(KIND_UNIX2FAT, 16'h0000, 16'h0000, 32'h7FFF_FFFF);
  endtask

  task automatic test_random_mix();
    repeat (950) random_request();
  endtask

  task automatic test_back_to_back();
    src_steady = 1'b1;
    sink_steady <= 1'b1;
    repeat (200) random_request();
    src_steady = 1'b0;
    sink_steady <= 1'b0;
  endtask

  task automatic test_output_stall();
    hold_req <= 1'b1;
    src_steady = 1'b1;
    repeat (100) random_request();
    src_steady = 1'b0;
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_fat_corners();
    test_unix_corners();
    test_random_mix();
    test_back_to_back();
    test_output_stall();
    in_valid <= 1'b0;
    while (pending_stamps.size() != 0) @(posedge clk);
    repeat (NUM_STAGES + 8) @(posedge clk);
    $display("%0d requests sent, %0d results checked", fat_requests + unix_requests,
             results_seen);
    $display("%0d FAT-to-Unix, %0d Unix-to-FAT (%0d clamped), with random and long stalls",
             fat_requests, unix_requests, clamp_requests);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
